### design/usbh_pkg.sv
// Shared widths, constants and register indexes of the universal string bucket hash.
package usbh_pkg;

  localparam int KEY_W    = 8;
  localparam int VAL_W    = 31;
  localparam int BKT_W    = 17;
  localparam int IDX_W    = 16;
  localparam int PROD_W   = 2 * VAL_W;
  localparam int CFG_W    = 31;
  localparam int REG_IDX_W = 2;

  localparam logic [VAL_W-1:0] HASH_PRIME = 31'h7FFF_FFFF;
  localparam int unsigned MAX_BUCKETS = 65536;

  localparam int DIV_STEPS = VAL_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [REG_IDX_W-1:0] REG_MULT_A       = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_ADD_B        = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_BUCKET_COUNT = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

### design/usbh_if.sv
// Valid/ready channel interfaces for the key-byte input and the hash result.
interface usbh_in_if import usbh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_byte;
  logic             has_byte;
  logic             last_byte;

  modport source (output valid, key_byte, has_byte, last_byte, input ready);
  modport sink   (input valid, key_byte, has_byte, last_byte, output ready);
endinterface

interface usbh_out_if import usbh_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] bucket_index;
  logic [VAL_W-1:0] universal_value;

  modport source (output valid, bucket_index, universal_value, input ready);
  modport sink   (input valid, bucket_index, universal_value, output ready);
endinterface

### design/usbh_divider.sv
// Iterative restoring remainder unit: one dividend bit per cycle.
module usbh_divider import usbh_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [VAL_W-1:0] dividend,
  input  logic [BKT_W-1:0] divisor,
  output div_stat_t        stat,
  output logic [IDX_W-1:0] remainder
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [VAL_W-1:0]     quo_r, quo_nxt;
  logic [IDX_W-1:0]     rem_r, rem_nxt;
  logic [BKT_W-1:0]     dvs_r, dvs_nxt;
  logic [BKT_W-1:0]     trial;

  assign trial = {rem_r, quo_r[VAL_W-1]};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = done_r;
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    if (start) begin
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
      cnt_nxt  = '0;
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (busy_r) begin
      quo_nxt = {quo_r[VAL_W-2:0], 1'b0};
      if (trial >= dvs_r) begin
        rem_nxt = IDX_W'(trial - dvs_r);
      end else begin
        rem_nxt = trial[IDX_W-1:0];
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> ({1'b0, rem_r} < dvs_r))
    else $error("remainder not below divisor");

  a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(busy_r && done_r))
    else $error("divider busy and done together");

  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> (busy_r && !done_r))
    else $error("divider did not start");

endmodule

### design/universal_string_bucket_hash_top.sv
// Top level of the universal string bucket hash: byte folding, mod-P finish, bucket reduction.
//
// Usage:
//   in_ch  : one key byte per transfer (key_byte, has_byte, last_byte).
//            has_byte folds key_byte into the running residue mod 2^31-1;
//            last_byte ends the key and requests one result. An item with
//            last_byte and no byte ends the key as is (covers the empty key).
//   out_ch : one transfer per key: universal_value = (a*residue + b) mod P and
//            bucket_index = universal_value mod bucket_count.
//   cfg_*  : write mult_a (0), add_b (1), bucket_count (2); write only while idle.
//            Bucket count 0 acts as one bucket; above 65536 it saturates to 65536.
// Flow: bytes that do not end the key are taken back to back. The result of a
//   key-ending transfer passes through multiply, two Mersenne fold steps, a start
//   state, the bit-serial remainder unit and the output load, in that order.
//   in_ch.ready is low meanwhile, so no byte of the next key is taken until the result is loaded.
// Stall: the result holds in an output register; bytes of the next key are taken
//   while it waits, and the next result holds in the divider until it drains.
// Reset: rst_n (synchronous, active low) clears the residue, drops any
//   pending result and restores a=1, b=0, bucket_count=1024.
module universal_string_bucket_hash_top import usbh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  usbh_in_if.sink              in_ch,
  usbh_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL  = 3'd1;
  localparam logic [2:0] ST_SUM  = 3'd2;
  localparam logic [2:0] ST_RED  = 3'd3;
  localparam logic [2:0] ST_DIVS = 3'd4;
  localparam logic [2:0] ST_DIVW = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [VAL_W-1:0]  mult_a_r, add_b_r;
  logic [BKT_W-1:0]  bucket_count_r;
  logic [VAL_W-1:0]  residue_r, residue_nxt;
  logic [PROD_W-1:0] prod_r;
  logic [VAL_W+1:0]  sum_r;
  logic [VAL_W-1:0]  value_r, value_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [IDX_W-1:0]  out_idx_r;
  logic [VAL_W-1:0]  out_val_r;

  logic              in_xfer, out_xfer, out_free;
  logic [VAL_W-1:0]  fold_lo;
  logic [VAL_W:0]    fold_sum;
  logic [VAL_W-1:0]  residue_fold;
  logic [VAL_W:0]    red_sum;
  logic [BKT_W-1:0]  bkt_eff;
  logic              div_start;
  div_stat_t         div_stat;
  logic [IDX_W-1:0]  div_rem;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_valid_r && out_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mult_a_r       <= VAL_W'(1);
      add_b_r        <= '0;
      bucket_count_r <= BKT_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_MULT_A:       mult_a_r       <= cfg_data[VAL_W-1:0];
        REG_ADD_B:        add_b_r        <= cfg_data[VAL_W-1:0];
        REG_BUCKET_COUNT: bucket_count_r <= cfg_data[BKT_W-1:0];
        default: ;
      endcase
    end
  end

  // residue*256 + byte mod P: bits above 2^31 wrap to the bottom, then one
  // conditional subtract (sum is always below 2P).
  assign fold_lo      = {residue_r[VAL_W-KEY_W-1:0], in_ch.key_byte};
  assign fold_sum     = {1'b0, fold_lo} + {{(VAL_W+1-KEY_W){1'b0}},
                                           residue_r[VAL_W-1:VAL_W-KEY_W]};
  assign residue_fold = (fold_sum >= {1'b0, HASH_PRIME}) ?
                        VAL_W'(fold_sum - {1'b0, HASH_PRIME}) : fold_sum[VAL_W-1:0];

  // Final fold of the three-term sum; result below 2^31+3, so one subtract.
  assign red_sum = {1'b0, sum_r[VAL_W-1:0]} + {{(VAL_W-1){1'b0}}, sum_r[VAL_W+1:VAL_W]};
  assign value_nxt = (red_sum >= {1'b0, HASH_PRIME}) ?
                     VAL_W'(red_sum - {1'b0, HASH_PRIME}) : red_sum[VAL_W-1:0];

  // Clamp the bucket count to one through the maximum.
  always_comb begin
    if (bucket_count_r == '0) begin
      bkt_eff = BKT_W'(1);
    end else if (32'(bucket_count_r) > MAX_BUCKETS) begin
      bkt_eff = BKT_W'(MAX_BUCKETS);
    end else begin
      bkt_eff = bucket_count_r;
    end
  end

  assign div_start = (state_r == ST_DIVS);

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    residue_nxt   = residue_r;
    out_valid_nxt = out_valid_r;
    if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_ch.has_byte) begin
            residue_nxt = residue_fold;
          end
          if (in_ch.last_byte) begin
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        residue_nxt = '0;        // product captured this cycle; clear for next key
        state_nxt   = ST_SUM;
      end
      ST_SUM:  state_nxt = ST_RED;
      ST_RED:  state_nxt = ST_DIVS;
      ST_DIVS: state_nxt = ST_DIVW;
      ST_DIVW: begin
        if (div_stat.done && out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      residue_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      residue_r   <= residue_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers: multiply, sum of halves plus offset, reduced value, output load.
  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      prod_r <= mult_a_r * residue_r;
    end
    if (state_r == ST_SUM) begin
      sum_r <= {2'b00, prod_r[VAL_W-1:0]} + {2'b00, prod_r[PROD_W-1:VAL_W]}
             + {2'b00, add_b_r};
    end
    if (state_r == ST_RED) begin
      value_r <= value_nxt;
    end
    if (state_r == ST_DIVW && div_stat.done && out_free) begin
      out_idx_r <= div_rem;
      out_val_r <= value_r;
    end
  end

  usbh_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (value_r),
    .divisor   (bkt_eff),
    .stat      (div_stat),
    .remainder (div_rem)
  );

  assign in_ch.ready            = (state_r == ST_IDLE);
  assign out_ch.valid           = out_valid_r;
  assign out_ch.bucket_index    = out_idx_r;
  assign out_ch.universal_value = out_val_r;

  a_residue_below_p: assert property (@(posedge clk) disable iff (!rst_n)
    residue_r != HASH_PRIME)
    else $error("residue reached the prime");

  a_value_below_p: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIVS) |-> (value_r != HASH_PRIME))
    else $error("universal value not reduced");

  a_last_starts_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.last_byte) |=> (state_r == ST_MUL))
    else $error("key end did not start the finish sequence");

  a_residue_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |=> (residue_r == '0))
    else $error("residue not cleared after key");

endmodule

### test/hash_result_checker.sv
// Checker for the universal string bucket hash: watches the channels, predicts and compares.
module hash_result_checker import usbh_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  usbh_in_if                   in_mon,
  usbh_out_if                  out_mon,
  input  logic                 cfg_we,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  output int                   fail_count,
  output int                   expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [IDX_W-1:0] bucket_index;
    logic [VAL_W-1:0] universal_value;
  } hash_result_t;

  hash_result_t     pending_hashes[$];
  logic [VAL_W-1:0] mult_a_q;
  logic [VAL_W-1:0] add_b_q;
  logic [BKT_W-1:0] bucket_count_q;
  logic [VAL_W-1:0] residue_q;

  function automatic logic [VAL_W-1:0] fold_byte(input logic [VAL_W-1:0] res,
                                                 input logic [KEY_W-1:0] kb);
    longint unsigned acc;
    acc = (64'(res) * 64'd256 + 64'(kb)) % 64'(HASH_PRIME);
    return acc[VAL_W-1:0];
  endfunction

  function automatic hash_result_t finish_key(input logic [VAL_W-1:0] res);
    longint unsigned v;
    longint unsigned n;
    hash_result_t    r;
    v = (64'(mult_a_q) * 64'(res) + 64'(add_b_q)) % 64'(HASH_PRIME);
    n = 64'(bucket_count_q);
    if (n == 0) n = 64'd1;
    if (n > 64'(MAX_BUCKETS)) n = 64'(MAX_BUCKETS);
    r.universal_value = v[VAL_W-1:0];
    r.bucket_index    = IDX_W'(v % n);
    return r;
  endfunction

  initial begin
    fail_count    = 0;
    expected_left = 0;
  end

  always @(posedge clk) begin
    hash_result_t want;
    if (!rst_n) begin
      mult_a_q       = VAL_W'(1);
      add_b_q        = '0;
      bucket_count_q = BKT_W'(1024);
      residue_q      = '0;
      pending_hashes.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_MULT_A:       mult_a_q       = cfg_data[VAL_W-1:0];
          REG_ADD_B:        add_b_q        = cfg_data[VAL_W-1:0];
          REG_BUCKET_COUNT: bucket_count_q = cfg_data[BKT_W-1:0];
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) begin
        if (pending_hashes.size() == 0) begin
          fail_count++;
          $display("%0t: unexpected result: expected none, actual index %0d value %0d",
                   $time, out_mon.bucket_index, out_mon.universal_value);
        end else begin
          want = pending_hashes.pop_front();
          if (out_mon.universal_value !== want.universal_value) begin
            fail_count++;
            $display("%0t: universal_value mismatch: expected %0d, actual %0d",
                     $time, want.universal_value, out_mon.universal_value);
          end
          if (out_mon.bucket_index !== want.bucket_index) begin
            fail_count++;
            $display("%0t: bucket_index mismatch: expected %0d, actual %0d",
                     $time, want.bucket_index, out_mon.bucket_index);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.has_byte) residue_q = fold_byte(residue_q, in_mon.key_byte);
        if (in_mon.last_byte) begin
          pending_hashes = {pending_hashes, finish_key(residue_q)};
          residue_q = '0;
        end
      end
    end
    expected_left <= pending_hashes.size();
  end

endmodule

### test/tb_universal_string_bucket_hash_top.sv
// Testbench top for the universal string bucket hash: stimulus, back-pressure and verdict.
module tb_universal_string_bucket_hash_top import usbh_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  // Worst case is far below this: about 1500 items, plus drains and the long hold.
  localparam int RUN_LIMIT    = 300000;
  localparam int LONG_HOLD    = 400;
  // Give the block room after key-ending work before config writes.
  localparam int SETTLE       = 48;
  localparam int PHASE_ITEMS  = 235;

  localparam logic [CFG_W-1:0] PRIME_CFG = CFG_W'(HASH_PRIME);

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [REG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  int                   fail_count;
  int                   expected_left;
  int                   items_sent;
  int                   cycle_count;
  logic                 tx_idle_en;
  logic                 rx_idle_en;
  logic                 long_hold_req;
  logic                 long_hold_done;

  usbh_in_if  key_ch();
  usbh_out_if hash_ch();

  universal_string_bucket_hash_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (key_ch),
    .out_ch    (hash_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  hash_result_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (key_ch),
    .out_mon       (hash_ch),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if the block hangs somewhere.
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // Result receiver: random ready bursts, one long hold on request, steady ready
  // once idling is switched off. Each pass assigns ready once, then advances.
  initial begin
    hash_ch.ready <= 1'b0;
    long_hold_done = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req && !long_hold_done) begin
        // Hold off long enough for the output register and divider to back up
        // and push the stall onto the input channel.
        hash_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end else if (rx_idle_en && $urandom_range(0, 3) == 0) begin
        hash_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 3)) @(posedge clk);
      end else begin
        hash_ch.ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  // Offer one item and hold it until the transfer; maybe idle first.
  task automatic send_item(input logic [KEY_W-1:0] kb, input logic has, input logic last);
    if (tx_idle_en && $urandom_range(0, 3) == 0) begin
      key_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    key_ch.valid     <= 1'b1;
    key_ch.key_byte  <= kb;
    key_ch.has_byte  <= has;
    key_ch.last_byte <= last;
    @(posedge clk);
    while (!key_ch.ready) @(posedge clk);
    // Items with neither flag are ignored by the block; leave them out of the tally.
    if (has || last) items_sent++;
  endtask

  // Drop valid and wait for every expected hash, then let the block settle.
  task automatic drain_hashes();
    key_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [REG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_hash_params(input logic [CFG_W-1:0] a, input logic [CFG_W-1:0] b,
                                 input logic [CFG_W-1:0] n);
    cfg_write(REG_MULT_A, a);
    cfg_write(REG_ADD_B, b);
    cfg_write(REG_BUCKET_COUNT, n);
  endtask

  // Bucket counts lean toward small and power-of-two values, with the odd
  // zero and over-range count to hit the clamping paths.
  function automatic logic [CFG_W-1:0] pick_bucket_count();
    case ($urandom_range(0, 5))
      0:       return CFG_W'($urandom_range(1, 16));
      1:       return CFG_W'(32'd1 << $urandom_range(0, 16));
      2:       return CFG_W'($urandom_range(1, 65536));
      3: begin
        case ($urandom_range(0, 3))
          0:       return CFG_W'(0);
          1:       return CFG_W'(65537);
          2:       return CFG_W'(131071);
          default: return CFG_W'(65535);
        endcase
      end
      default: return CFG_W'($urandom_range(1, 1024));
    endcase
  endfunction

  task automatic random_hash_params();
    set_hash_params(CFG_W'($urandom_range(1, 32'h7FFF_FFFE)),
                    CFG_W'($urandom_range(0, 32'h7FFF_FFFE)),
                    pick_bucket_count());
  endtask

  // One well-formed key with random bytes; sprinkle ignored items in between
  // and end either on the last byte or with a separate byte-less end item.
  task automatic send_random_key();
    int   len;
    int   pick;
    logic end_on_byte;
    pick = $urandom_range(0, 9);
    if (pick == 0) len = 0;
    else if (pick < 8) len = $urandom_range(1, 6);
    else len = $urandom_range(7, 24);
    end_on_byte = (len > 0) && ($urandom_range(0, 1) == 1);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 11) == 0) send_item(KEY_W'($urandom_range(0, 255)), 1'b0, 1'b0);
      if (i == len - 1 && end_on_byte)
        send_item(KEY_W'($urandom_range(0, 255)), 1'b1, 1'b1);
      else
        send_item(KEY_W'($urandom_range(0, 255)), 1'b1, 1'b0);
    end
    if (!end_on_byte) send_item(KEY_W'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic run_keys(input int n_items);
    int target;
    target = items_sent + n_items;
    while (items_sent < target) send_random_key();
  endtask

  initial begin
    rst_n            <= 1'b0;
    key_ch.valid     <= 1'b0;
    key_ch.key_byte  <= '0;
    key_ch.has_byte  <= 1'b0;
    key_ch.last_byte <= 1'b0;
    cfg_we           <= 1'b0;
    cfg_index        <= REG_MULT_A;
    cfg_data         <= '0;
    items_sent       = 0;
    tx_idle_en       = 1'b1;
    rx_idle_en       = 1'b1;
    long_hold_req    = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, first on the reset settings (a=1, b=0, 1024 buckets).
    send_item(8'hA5, 1'b0, 1'b1);             // empty key, byte ignored
    send_item(8'h3C, 1'b0, 1'b0);             // neither flag: no effect
    send_item(8'h00, 1'b1, 1'b1);             // byte folded, then key ends
    send_item(8'hFF, 1'b1, 1'b1);
    repeat (5) send_item(8'hFF, 1'b1, 1'b0);  // residue wraps past the prime
    send_item(8'h5A, 1'b0, 1'b1);
    drain_hashes();

    // Multiplier and offset equal to the prime; zero buckets acts as one.
    set_hash_params(PRIME_CFG, PRIME_CFG, CFG_W'(0));
    send_item(8'h80, 1'b1, 1'b0);
    send_item(8'h7F, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
    drain_hashes();

    // Zero multiplier; bucket count above the maximum saturates.
    set_hash_params(CFG_W'(0), CFG_W'(PRIME_CFG - 1), CFG_W'(131071));
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h01, 1'b1, 1'b1);
    drain_hashes();

    // Top legal values; index taken from the low 16 bits with 65536 buckets.
    set_hash_params(CFG_W'(PRIME_CFG - 1), CFG_W'(PRIME_CFG - 1), CFG_W'(65536));
    repeat (4) send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h80, 1'b1, 1'b1);
    drain_hashes();

    cfg_write(REG_BUCKET_COUNT, CFG_W'(1));
    send_item(8'h42, 1'b1, 1'b1);
    drain_hashes();

    // Random part, one configuration per phase.
    random_hash_params();
    run_keys(PHASE_ITEMS);
    drain_hashes();

    // Extremes, with the receiver holding off long enough to fill the block.
    set_hash_params(CFG_W'(PRIME_CFG - 1), CFG_W'(PRIME_CFG - 1), CFG_W'(65536));
    long_hold_req = 1'b1;
    run_keys(PHASE_ITEMS);
    drain_hashes();

    random_hash_params();
    run_keys(PHASE_ITEMS);
    drain_hashes();

    set_hash_params(CFG_W'(1), CFG_W'(0), CFG_W'(1));
    run_keys(PHASE_ITEMS);
    drain_hashes();

    random_hash_params();
    run_keys(PHASE_ITEMS);
    drain_hashes();

    // Closing stretch at full rate: no idling on either side.
    random_hash_params();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    run_keys(PHASE_ITEMS - 10);
    drain_hashes();

    repeat (60) @(posedge clk);
    if (fail_count == 0 && expected_left == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
